// ===== sv/rle_pkg.sv =====
// Package for the byte run-length encoder.
// Holds the coding constants, the result buffer sizing and the buffer entry type.
// No dependencies.
package rle_pkg;

   // Coding constants of the scheme.
   localparam logic [7:0] RUN_FLAG  = 8'h80;
   localparam logic [6:0] RUN_CHUNK = 7'd127;
   localparam logic [7:0] CONT_BYTE = 8'hFF;

   // The result buffer holds four entries, so two more always fit while ready is high.
   localparam int unsigned BUF_DEPTH = 4;
   localparam int unsigned BUF_AW    = $clog2(BUF_DEPTH);
   localparam int unsigned BUF_CW    = $clog2(BUF_DEPTH + 1);

   // This is one compressed byte together with its end-of-buffer mark.
   typedef struct packed {
      logic [7:0] code_byte;
      logic       last_out;
   } rle_entry_type;

endpackage

// ===== sv/rle_stream_ifs.sv =====
// Valid/ready stream interfaces of the byte run-length encoder.
// The request interface carries raw bytes and the response interface carries coded bytes.
// No dependencies.
interface rle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_in;

   modport source (output valid, output data_byte, output last_in, input ready);
   modport sink   (input valid, input data_byte, input last_in, output ready);
endinterface

interface rle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       last_out;

   modport source (output valid, output code_byte, output last_out, input ready);
   modport sink   (input valid, input code_byte, input last_out, output ready);
endinterface

// ===== sv/rle_byte_encoder_core.sv =====
// Output: a coded byte is written into the result buffer at the transfer that causes it,
// and rsp_ch offers it from there. Throughput: one input byte per cycle while req_ch.ready
// is high. A byte may yield two coded bytes, which the four-entry result buffer absorbs;
// req_ch.ready drops only when fewer than two buffer entries are free.
// Reset: synchronous and active high. It empties the pending run and the result buffer.
// Top level of the byte run-length encoder.
// Depends on rle_pkg and the interfaces in rle_stream_ifs.sv.
module rle_byte_encoder_core
   import rle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rle_req_if.sink     req_ch,
   rle_rsp_if.source   rsp_ch
);

   // Run state.
   logic [7:0] held_value_ff, held_value_in;
   logic       have_held_ff, have_held_in;
   logic       header_sent_ff, header_sent_in;
   logic [6:0] run_remainder_ff, run_remainder_in;

   // Result buffer.
   rle_entry_type        buf_mem_ff [BUF_DEPTH];
   logic [BUF_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [BUF_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [BUF_CW-1:0]    count_ff, count_in;

   logic          req_xfer;
   logic          rsp_xfer;
   logic          emit_step;
   logic [7:0]    step_byte;
   logic [1:0]    push_count;
   rle_entry_type first_entry;
   rle_entry_type second_entry;
   logic [7:0]    close_byte;

   // Handshakes: accept while two entries are free, offer while the buffer holds data.
   assign req_ch.ready = (count_ff <= BUF_CW'(BUF_DEPTH - 2));
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = (count_ff != '0);
   assign rsp_xfer     = rsp_ch.valid && rsp_ch.ready;
   assign rsp_ch.code_byte = buf_mem_ff[rd_ptr_ff].code_byte;
   assign rsp_ch.last_out  = buf_mem_ff[rd_ptr_ff].last_out;

   // Step logic: start, extend or close the pending run, then flush it on the last byte.
   always_comb begin
      emit_step        = 1'b0;
      step_byte        = CONT_BYTE;
      held_value_in    = held_value_ff;
      have_held_in     = have_held_ff;
      header_sent_in   = header_sent_ff;
      run_remainder_in = run_remainder_ff;

      if (!have_held_ff) begin
         held_value_in    = req_ch.data_byte;
         have_held_in     = 1'b1;
         header_sent_in   = 1'b0;
         run_remainder_in = 7'd1;
      end else if (req_ch.data_byte == held_value_ff) begin
         if (!header_sent_ff) begin
            emit_step        = 1'b1;
            step_byte        = held_value_ff | RUN_FLAG;
            header_sent_in   = 1'b1;
            run_remainder_in = 7'd2;
         end else if (run_remainder_ff >= RUN_CHUNK) begin
            emit_step        = 1'b1;
            step_byte        = CONT_BYTE;
            run_remainder_in = 7'd1;
         end else begin
            run_remainder_in = run_remainder_ff + 7'd1;
         end
      end else begin
         emit_step        = 1'b1;
         step_byte        = header_sent_ff ? {1'b0, run_remainder_ff} : held_value_ff;
         held_value_in    = req_ch.data_byte;
         header_sent_in   = 1'b0;
         run_remainder_in = 7'd1;
      end

      // The flush closes the run as it stands after this byte.
      close_byte = header_sent_in ? {1'b0, run_remainder_in} : held_value_in;

      if (req_ch.last_in) begin
         held_value_in    = '0;
         have_held_in     = 1'b0;
         header_sent_in   = 1'b0;
         run_remainder_in = '0;
      end
   end

   // Order the coded bytes of this step for the buffer.
   always_comb begin
      second_entry.code_byte = close_byte;
      second_entry.last_out  = 1'b1;
      if (emit_step) begin
         first_entry.code_byte = step_byte;
         first_entry.last_out  = 1'b0;
      end else begin
         first_entry = second_entry;
      end
      push_count = {1'b0, emit_step} + {1'b0, req_ch.last_in};
   end

   // Buffer pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_xfer) begin
         wr_ptr_in = wr_ptr_ff + BUF_AW'(push_count);
         count_in  = count_ff + BUF_CW'(push_count);
      end
      if (rsp_xfer) begin
         rd_ptr_in = rd_ptr_ff + BUF_AW'(1);
         count_in  = count_in - BUF_CW'(1);
      end
   end

   // Control and run state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_value_ff    <= '0;
         have_held_ff     <= 1'b0;
         header_sent_ff   <= 1'b0;
         run_remainder_ff <= '0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         count_ff         <= '0;
      end else begin
         if (req_xfer) begin
            held_value_ff    <= held_value_in;
            have_held_ff     <= have_held_in;
            header_sent_ff   <= header_sent_in;
            run_remainder_ff <= run_remainder_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Buffer storage takes up to two entries per transfer.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         if (push_count != 2'd0) begin
            buf_mem_ff[wr_ptr_ff] <= first_entry;
         end
         if (push_count == 2'd2) begin
            buf_mem_ff[wr_ptr_ff + BUF_AW'(1)] <= second_entry;
         end
      end
   end

`ifndef ASSERT_OFF
   // The buffer never holds more entries than it has.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= BUF_CW'(BUF_DEPTH))
      else $error("result buffer overfilled");

   // A pending run always has a remainder of 1 to 127.
   a_remainder_range : assert property (@(posedge clock) disable iff (reset)
      have_held_ff |-> (run_remainder_ff != '0 && run_remainder_ff <= RUN_CHUNK))
      else $error("run remainder out of range");

   // Without a pending run no header can be outstanding.
   a_header_needs_run : assert property (@(posedge clock) disable iff (reset)
      !have_held_ff |-> !header_sent_ff)
      else $error("header marked sent without a pending run");

   // A transfer marked last leaves the encoder empty.
   a_last_flushes : assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_ch.last_in) |=> !have_held_ff)
      else $error("run still pending after the last byte");

   // A transfer marked last always leaves a coded byte to deliver.
   a_last_emits : assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_ch.last_in) |=> rsp_ch.valid)
      else $error("no coded byte after the last byte");
`endif

endmodule
